/* hdl/sorted_key_set_top_macros.svh */
// ----------------------------------------------------------------------------
// Sorted key set assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_SET_TOP_MACROS_SVH
`define SORTED_KEY_SET_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKSET_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKSET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/skset_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted key set package
// Beat types, command and status codes, and size constants.
// ----------------------------------------------------------------------------
package skset_pkg;

  // Field widths fixed by the interface.
  localparam int KEY_BITS     = 48;
  localparam int OCC_BITS     = 7;
  localparam int CAPACITY_DEF = 64;

  // Command codes.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Input beat.
  typedef struct packed {
    logic [1:0]          command;
    logic [KEY_BITS-1:0] key;
  } skset_in_t;

  // Result beat.
  typedef struct packed {
    logic [1:0]          status;
    logic                found;
    logic [OCC_BITS-1:0] occupancy;
  } skset_out_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
  } skset_ctrl_t;

endpackage

/* hdl/skset_cell.sv */
// ----------------------------------------------------------------------------
// Sorted key set cell
// Holds one key, compares it with the command key and shifts it to or
// from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module skset_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  skset_pkg::skset_ctrl_t        ctrl,
  input  logic [skset_pkg::KEY_BITS-1:0] cmd_key,
  input  logic                          slot_valid,
  input  logic                          left_lt,
  input  logic [skset_pkg::KEY_BITS-1:0] left_key,
  input  logic [skset_pkg::KEY_BITS-1:0] right_key,
  output logic                          lt,
  output logic                          eq,
  output logic [skset_pkg::KEY_BITS-1:0] key
);

  logic                          lt_r;
  logic                          eq_r;
  logic [skset_pkg::KEY_BITS-1:0] key_r;
  logic [skset_pkg::KEY_BITS-1:0] key_nxt;

  // Compare flags, captured in the compare cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctrl.cmp) begin
      lt_r <= slot_valid && (key_r < cmd_key);
      eq_r <= slot_valid && (key_r == cmd_key);
    end
  end

  // Cells below the insert point keep their key; the first cell at or past
  // it takes the new key and the rest take the key from the left. On a
  // remove, every cell at or past the match takes the key from the right.
  always_comb begin
    key_nxt = key_r;
    if (ctrl.ins && !lt_r) begin
      key_nxt = left_lt ? cmd_key : left_key;
    end else if (ctrl.rem && !lt_r) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign lt  = lt_r;
  assign eq  = eq_r;
  assign key = key_r;

endmodule

/* hdl/sorted_key_set_top.sv */
// ----------------------------------------------------------------------------
// Sorted key set top level
// A command beat is accepted at a rising edge with start high and busy low.
// busy then stays high through the compare and update states. In the compare
// state, every cell compares its key with the command key in parallel. In the
// update state, the match flags are reduced and, for an insert or a remove
// that takes effect, the chain shifts by one place. No new command is taken
// before that, whatever the occupancy. Every command yields one result beat,
// shown for exactly one cycle with out_valid in the cycle after the update
// state, the first that can accept a new command. The receiver cannot stall it.
// ----------------------------------------------------------------------------
`include "sorted_key_set_top_macros.svh"

module sorted_key_set_top #(
  parameter int CAPACITY = skset_pkg::CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  skset_pkg::skset_in_t  in_beat,
  output logic                  out_valid,
  output skset_pkg::skset_out_t out_beat
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t                         state_r;
  state_t                         state_nxt;
  logic [1:0]                     cmd_r;
  logic [skset_pkg::KEY_BITS-1:0] key_r;
  logic [CNT_W-1:0]               count_r;
  logic [CNT_W-1:0]               count_nxt;
  logic                           out_valid_r;
  skset_pkg::skset_out_t          out_beat_r;
  skset_pkg::skset_out_t          out_beat_nxt;
  skset_pkg::skset_ctrl_t         ctrl;
  logic                           accept;
  logic                           hit;
  logic                           full;

  logic [CAPACITY-1:0]            lt_vec;
  logic [CAPACITY-1:0]            eq_vec;
  logic [skset_pkg::KEY_BITS-1:0] cell_key [CAPACITY];

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Sequencer.
  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_CMP : S_IDLE;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command beat capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_beat.command;
      key_r <= in_beat.key;
    end
  end

  // Match reduction and the decision for this command.
  assign hit  = |eq_vec;
  assign full = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    ctrl.cmp = (state_r == S_CMP);
    ctrl.ins = (state_r == S_UPD) && (cmd_r == skset_pkg::CMD_INSERT) && !hit && !full;
    ctrl.rem = (state_r == S_UPD) && (cmd_r == skset_pkg::CMD_REMOVE) && hit;
  end

  // Occupancy update.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result beat.
  always_comb begin
    out_beat_nxt.status    = skset_pkg::ST_DONE;
    out_beat_nxt.found     = 1'b0;
    out_beat_nxt.occupancy = skset_pkg::OCC_BITS'(count_nxt);
    case (cmd_r)
      skset_pkg::CMD_INSERT: begin
        if (hit) begin
          out_beat_nxt.status = skset_pkg::ST_DUP;
        end else if (full) begin
          out_beat_nxt.status = skset_pkg::ST_FULL;
        end
      end
      skset_pkg::CMD_REMOVE: begin
        if (!hit) begin
          out_beat_nxt.status = skset_pkg::ST_NOTFOUND;
        end
      end
      skset_pkg::CMD_FIND: begin
        out_beat_nxt.found = hit;
      end
      default: begin
        out_beat_nxt.found = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // Chain of cells, lowest key at index zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                           slot_valid;
    logic                           left_lt;
    logic [skset_pkg::KEY_BITS-1:0] left_key;
    logic [skset_pkg::KEY_BITS-1:0] right_key;

    assign slot_valid = (count_r > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_key = key_r;
    end else begin : g_inner
      assign left_lt  = lt_vec[i-1];
      assign left_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_body
      assign right_key = cell_key[i+1];
    end

    skset_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .cmd_key    (key_r),
      .slot_valid (slot_valid),
      .left_lt    (left_lt),
      .left_key   (left_key),
      .right_key  (right_key),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i]),
      .key        (cell_key[i])
    );
  end

  // Assertions.
  `SKSET_ASSERT_SAME(a_result_when_idle, clk, rst_n, out_valid, !busy, "result beat while busy")
  `SKSET_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy && !out_valid, "accepted command did not go busy")
  `SKSET_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY), "occupancy beyond capacity")
  `SKSET_ASSERT_SAME(a_single_match, clk, rst_n, state_r == S_UPD, $onehot0(eq_vec), "more than one cell matched")

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Sorted key set testbench
// Drives insert, remove and find commands, with the one unused command code,
// into the block. A scoreboard keeps its own sorted copy of the key set,
// predicts each result beat and checks every result beat against the
// oldest prediction. Phases fill the store past full, churn it and drain it
// again, under several amounts of sender idling.
// ----------------------------------------------------------------------------
module tb;
  import skset_pkg::*;

  // The unused command code, which the block must ignore.
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int CAPACITY = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 200000;

  // Scoreboard: a sorted copy of the held keys and the results still due.
  class key_set_scoreboard;
    logic [KEY_BITS-1:0] held_keys[$];
    skset_out_t due_results[$];
    int errors;
    int commands;
    int results;
    int status_seen[4];
    int peak_count;

    function new();
      errors = 0;
      commands = 0;
      results = 0;
      peak_count = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Apply one accepted command to the key set and queue its result.
    function void note_command(skset_in_t beat);
      skset_out_t res;
      int pos;
      bit hit;
      pos = 0;
      while (pos < held_keys.size() && held_keys[pos] < beat.key) pos++;
      hit = (pos < held_keys.size()) && (held_keys[pos] == beat.key);
      res.status = ST_DONE;
      res.found = 1'b0;
      case (beat.command)
        CMD_INSERT: begin
          if (hit) begin
            res.status = ST_DUP;
          end else if (held_keys.size() >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            held_keys.insert(pos, beat.key);
          end
        end
        CMD_REMOVE: begin
          if (!hit) begin
            res.status = ST_NOTFOUND;
          end else begin
            held_keys.delete(pos);
          end
        end
        CMD_FIND: begin
          res.found = hit;
        end
        default: begin
        end
      endcase
      res.occupancy = OCC_BITS'(held_keys.size());
      if (held_keys.size() > peak_count) peak_count = held_keys.size();
      status_seen[res.status]++;
      commands++;
      due_results.push_back(res);
    endfunction

    // Compare one result beat, field by field, with the oldest prediction.
    function void check_result(skset_out_t got);
      skset_out_t want;
      results++;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected: status %0d found %0d occupancy %0d",
                 $time, got.status, got.found, got.occupancy);
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, got.status);
      end
      if (got.found !== want.found) begin
        errors++;
        $display("%0t: found mismatch: expected %0d, got %0d", $time, want.found, got.found);
      end
      if (got.occupancy !== want.occupancy) begin
        errors++;
        $display("%0t: occupancy mismatch: expected %0d, got %0d",
                 $time, want.occupancy, got.occupancy);
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // A fresh key, weighted toward the ends of the key range.
    function logic [KEY_BITS-1:0] fresh_key();
      logic [63:0] wide;
      case ($urandom_range(9))
        0: fresh_key = '0;
        1: fresh_key = '1;
        2: fresh_key = KEY_BITS'($urandom_range(15));
        3: fresh_key = {{(KEY_BITS-4){1'b1}}, 4'($urandom_range(15))};
        default: begin
          wide = {$urandom, $urandom};
          fresh_key = wide[KEY_BITS-1:0];
        end
      endcase
    endfunction

    // Mostly a held key (or a neighbor of one) when hit_pct is high.
    function logic [KEY_BITS-1:0] pick_key(int hit_pct);
      logic [KEY_BITS-1:0] k;
      if (held_keys.size() > 0 && $urandom_range(99) < hit_pct) begin
        k = held_keys[$urandom_range(held_keys.size() - 1)];
        case ($urandom_range(9))
          0: k = k + 1'b1;
          1: k = k - 1'b1;
          default: begin
          end
        endcase
        return k;
      end
      return fresh_key();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  skset_in_t in_beat;
  logic out_valid;
  skset_out_t out_beat;
  int cycle_count = 0;
  key_set_scoreboard ledger = new();

  sorted_key_set_top #(
    .CAPACITY (CAPACITY)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

  always #2 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results still due.", ledger.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Every result beat is taken in the cycle it is shown.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) ledger.check_result(out_beat);
  end

  // Issue one command beat, after an optional idle gap, and wait until it is taken.
  task automatic issue_command(input logic [1:0] cmd, input logic [KEY_BITS-1:0] key,
                               input int idle_pct);
    skset_in_t beat;
    beat.command = cmd;
    beat.key = key;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_beat <= beat;
    do @(posedge clk); while (busy !== 1'b0);
    ledger.note_command(beat);
  endtask

  // A run of random commands with the given mix of operations and key reuse.
  task automatic run_mix(input int count, input int idle_pct, input int ins_pct,
                         input int rem_pct, input int hit_pct);
    int r;
    logic [1:0] cmd;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 3) cmd = CMD_NONE;
      else if (r < 3 + ins_pct) cmd = CMD_INSERT;
      else if (r < 3 + ins_pct + rem_pct) cmd = CMD_REMOVE;
      else cmd = CMD_FIND;
      issue_command(cmd, ledger.pick_key(hit_pct), idle_pct);
    end
  endtask

  initial begin
    int idle_pct[3];
    idle_pct = '{0, 50, 13};
    rst_n <= 1'b0;
    start <= 1'b0;
    in_beat <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, key extremes, duplicates, misses and the unused code.
    issue_command(CMD_FIND, '0, 0);
    issue_command(CMD_REMOVE, '0, 0);
    issue_command(CMD_INSERT, '1, 0);
    issue_command(CMD_INSERT, '0, 0);
    issue_command(CMD_INSERT, '0, 0);
    issue_command(CMD_INSERT, '1, 0);
    issue_command(CMD_INSERT, 48'h8000_0000_0000, 0);
    issue_command(CMD_INSERT, 48'h7fff_ffff_ffff, 0);
    issue_command(CMD_FIND, '1, 0);
    issue_command(CMD_FIND, 48'h5555_5555_5555, 0);
    issue_command(CMD_INSERT, 48'h5555_5555_5555, 0);
    issue_command(CMD_INSERT, 48'haaaa_aaaa_aaaa, 0);
    issue_command(CMD_FIND, 48'h5555_5555_5555, 0);
    issue_command(CMD_NONE, 48'haaaa_aaaa_aaaa, 0);
    issue_command(CMD_REMOVE, '0, 0);
    issue_command(CMD_REMOVE, '0, 0);
    issue_command(CMD_FIND, '0, 0);
    issue_command(CMD_REMOVE, 48'h8000_0000_0000, 0);
    issue_command(CMD_REMOVE, '1, 0);
    issue_command(CMD_INSERT, 48'h0000_0000_0001, 0);
    issue_command(CMD_NONE, '1, 0);

    // Random: per idling phase, fill past full, churn, then drain past empty.
    foreach (idle_pct[p]) begin
      run_mix(160, idle_pct[p], 85, 5, 15);
      run_mix(220, idle_pct[p], 35, 35, 50);
      run_mix(170, idle_pct[p], 10, 75, 70);
    end

    @(posedge clk);
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Issued %0d commands and checked %0d result beats; peak occupancy %0d of %0d.",
             ledger.commands, ledger.results, ledger.peak_count, CAPACITY);
    $display("Statuses seen: %0d done, %0d duplicate, %0d not found, %0d full.",
             ledger.status_seen[ST_DONE], ledger.status_seen[ST_DUP],
             ledger.status_seen[ST_NOTFOUND], ledger.status_seen[ST_FULL]);
    if (ledger.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
